[hw/rtl/group_membership_fanout_assert.svh]
// Assertion macros for the checker file of the group fan-out block.
// Depends on nothing; included by bare file name.
`ifndef GROUP_MEMBERSHIP_FANOUT_ASSERT_SVH
`define GROUP_MEMBERSHIP_FANOUT_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define GMF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define GMF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/gmf_pkg.sv]
// Package of the group fan-out block: widths, constants, entry, push and state types.
// Depends on nothing.
`default_nettype none

package gmf_pkg;

    localparam int ID_W            = 32;
    localparam int GRP_W           = 8;
    localparam int TABLE_DEPTH_DEF = 64;

    // ASCII '0' maps to group zero
    localparam logic [GRP_W-1:0] GROUP_BIAS = 8'd48;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [GRP_W-1:0] grp;
    } gmf_entry_t;

    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] dest_id;
        logic            last;
    } gmf_push_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_FANOUT
    } gmf_state_t;

endpackage

`default_nettype wire

[hw/rtl/gmf_in_if.sv]
// Message input channel: valid/ready with sender id and first text byte.
// Depends on gmf_pkg.
`default_nettype none

interface gmf_in_if;
    import gmf_pkg::*;

    logic             valid;
    logic             ready;
    logic [ID_W-1:0]  sender_id;
    logic [GRP_W-1:0] first_byte;

    modport source (output valid, output sender_id, output first_byte, input ready);
    modport sink   (input valid, input sender_id, input first_byte, output ready);
endinterface

`default_nettype wire

[hw/rtl/gmf_out_if.sv]
// Forward output channel: valid/ready with destination id and last marker.
// Depends on gmf_pkg.
`default_nettype none

interface gmf_out_if;
    import gmf_pkg::*;

    logic            valid;
    logic            ready;
    logic [ID_W-1:0] dest_id;
    logic            last;

    modport source (output valid, output dest_id, output last, input ready);
    modport sink   (input valid, input dest_id, input last, output ready);
endinterface

`default_nettype wire

[hw/rtl/gmf_table.sv]
// Member table: synchronous memory of id and group entries, registered read.
// Depends on gmf_pkg.
`default_nettype none

module gmf_table #(
    parameter int DEPTH = gmf_pkg::TABLE_DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  wire                  clk,
    input  wire                  re,
    input  wire [IDX_W-1:0]      raddr,
    output gmf_pkg::gmf_entry_t  rdata,
    input  wire                  we,
    input  wire [IDX_W-1:0]      waddr,
    input  gmf_pkg::gmf_entry_t  wdata
);
    import gmf_pkg::*;

    gmf_entry_t mem [DEPTH];
    gmf_entry_t rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hw/rtl/gmf_out_buf.sv]
// One-entry output register between the scan engine and the forward channel.
// Depends on gmf_pkg and gmf_out_if.
`default_nettype none

module gmf_out_buf (
    input  wire               clk,
    input  wire               rst_n,
    input  gmf_pkg::gmf_push_t push,
    output logic              push_ok,
    gmf_out_if.source         fwd_out
);
    import gmf_pkg::*;

    logic            vld_reg;
    logic            vld_next;
    logic [ID_W-1:0] dest_id_reg;
    logic            last_reg;

    // Take a new result when empty or when the held one leaves this cycle
    assign push_ok = !vld_reg || fwd_out.ready;

    always_comb
    begin
        vld_next = vld_reg;
        if (push.valid)
        begin
            vld_next = 1'b1;
        end
        else if (fwd_out.ready)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Load the payload on every push
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            dest_id_reg <= push.dest_id;
            last_reg    <= push.last;
        end
    end

    assign fwd_out.valid   = vld_reg;
    assign fwd_out.dest_id = dest_id_reg;
    assign fwd_out.last    = last_reg;

endmodule

`default_nettype wire

[hw/rtl/gmf_ctrl.sv]
// Scan engine: looks up the sender, registers new members, walks the group.
// Depends on gmf_pkg and gmf_in_if; drives gmf_table and gmf_out_buf.
`default_nettype none

module gmf_ctrl #(
    parameter int DEPTH = gmf_pkg::TABLE_DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH),
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire                 clk,
    input  wire                 rst_n,
    gmf_in_if.sink              msg_in,
    output logic                re,
    output logic [IDX_W-1:0]    raddr,
    input  gmf_pkg::gmf_entry_t rdata,
    output logic                we,
    output logic [IDX_W-1:0]    waddr,
    output gmf_pkg::gmf_entry_t wdata,
    output gmf_pkg::gmf_push_t  push,
    input  wire                 push_ok
);
    import gmf_pkg::*;

    gmf_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] addr_reg, addr_next;
    logic             chk_vld_reg, chk_vld_next;
    logic             pend_vld_reg, pend_vld_next;
    logic [ID_W-1:0]  sender_reg, sender_next;
    logic [GRP_W-1:0] byte_reg, byte_next;
    logic [GRP_W-1:0] grp_reg, grp_next;
    logic [ID_W-1:0]  pend_id_reg, pend_id_next;

    logic issue;
    logic scan_done;
    logic hit;
    logic match;
    logic stall;

    // Scan status
    assign issue     = addr_reg < count_reg;
    assign scan_done = !chk_vld_reg && !issue;
    assign hit       = chk_vld_reg && (rdata.id == sender_reg);
    assign match     = chk_vld_reg && (rdata.grp == grp_reg) && (rdata.id != sender_reg);
    assign stall     = match && pend_vld_reg && !push_ok;

    assign msg_in.ready = (state_reg == ST_IDLE);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg_in.valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (hit)
                begin
                    state_next = ST_FANOUT;
                end
                else if (scan_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FANOUT:
            begin
                if (scan_done && (!pend_vld_reg || push_ok))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory accesses, pushes and datapath updates
    always_comb
    begin
        count_next    = count_reg;
        addr_next     = addr_reg;
        chk_vld_next  = chk_vld_reg;
        pend_vld_next = pend_vld_reg;
        sender_next   = sender_reg;
        byte_next     = byte_reg;
        grp_next      = grp_reg;
        pend_id_next  = pend_id_reg;
        re            = 1'b0;
        raddr         = addr_reg[IDX_W-1:0];
        we            = 1'b0;
        waddr         = count_reg[IDX_W-1:0];
        wdata.id      = sender_reg;
        wdata.grp     = byte_reg - GROUP_BIAS;
        push          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                // Capture the message and restart the scan
                if (msg_in.valid)
                begin
                    sender_next   = msg_in.sender_id;
                    byte_next     = msg_in.first_byte;
                    addr_next     = '0;
                    chk_vld_next  = 1'b0;
                    pend_vld_next = 1'b0;
                end
            end
            ST_LOOKUP:
            begin
                if (hit)
                begin
                    // Sender known: take its group and rescan from the top
                    grp_next     = rdata.grp;
                    addr_next    = '0;
                    chk_vld_next = 1'b0;
                end
                else
                begin
                    re           = issue;
                    chk_vld_next = issue;
                    if (issue)
                    begin
                        addr_next = addr_reg + 1'b1;
                    end
                    // Unknown sender: append unless the table is full
                    if (scan_done && (count_reg < CNT_W'(DEPTH)))
                    begin
                        we         = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            ST_FANOUT:
            begin
                if (!stall)
                begin
                    re           = issue;
                    chk_vld_next = issue;
                    if (issue)
                    begin
                        addr_next = addr_reg + 1'b1;
                    end
                    // Hold each match until the next one shows it is not the last
                    if (match)
                    begin
                        if (pend_vld_reg)
                        begin
                            push.valid   = 1'b1;
                            push.dest_id = pend_id_reg;
                            push.last    = 1'b0;
                        end
                        pend_id_next  = rdata.id;
                        pend_vld_next = 1'b1;
                    end
                end
                // Release the final match with the last marker
                if (scan_done && pend_vld_reg && push_ok)
                begin
                    push.valid    = 1'b1;
                    push.dest_id  = pend_id_reg;
                    push.last     = 1'b1;
                    pend_vld_next = 1'b0;
                end
            end
            default:
            begin
                push = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            addr_reg     <= '0;
            chk_vld_reg  <= 1'b0;
            pend_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            addr_reg     <= addr_next;
            chk_vld_reg  <= chk_vld_next;
            pend_vld_reg <= pend_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sender_reg  <= sender_next;
        byte_reg    <= byte_next;
        grp_reg     <= grp_next;
        pend_id_reg <= pend_id_next;
    end

endmodule

`default_nettype wire

[hw/rtl/group_membership_fanout.sv]
// Channel   Dir  Payload                          Transfer
// msg_in    in   sender_id[31:0], first_byte[7:0]  valid && ready
// fwd_out   out  dest_id[31:0], last               valid && ready
//
// One message at a time: the input closes at each transfer until the scan ends.
// A new sender is looked up through the stored members, then appended unless
// the table is full; a known sender is found at its index, then the table is
// scanned again for its group, waiting while the forward channel holds ready
// low. All scans go through the single read port of the member table.
// Reset clears the member count and control; table contents need no clearing.
// The next message is taken once the last forward sits in the output register.
//
// Top level of the group fan-out block. Depends on gmf_pkg, gmf_in_if,
// gmf_out_if, gmf_table, gmf_out_buf and gmf_ctrl.
`default_nettype none

module group_membership_fanout #(
    parameter int TABLE_DEPTH = gmf_pkg::TABLE_DEPTH_DEF
) (
    input  wire       clk,
    input  wire       rst_n,
    gmf_in_if.sink    msg_in,
    gmf_out_if.source fwd_out
);
    import gmf_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic             re;
    logic [IDX_W-1:0] raddr;
    gmf_entry_t       rdata;
    logic             we;
    logic [IDX_W-1:0] waddr;
    gmf_entry_t       wdata;
    gmf_push_t        push;
    logic             push_ok;

    // Member table
    gmf_table #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_table (
        .clk   (clk),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata)
    );

    // Lookup, registration and fan-out sequencing
    gmf_ctrl #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .msg_in  (msg_in),
        .re      (re),
        .raddr   (raddr),
        .rdata   (rdata),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .push    (push),
        .push_ok (push_ok)
    );

    // Output register
    gmf_out_buf u_out_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_ok (push_ok),
        .fwd_out (fwd_out)
    );

endmodule

`default_nettype wire

[hw/rtl/gmf_checker.sv]
// Port-level checker for the group fan-out block, bound to its top level.
// Depends on group_membership_fanout_assert.svh.
`default_nettype none

`include "group_membership_fanout_assert.svh"

module gmf_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        in_valid,
    input wire        in_ready,
    input wire        out_valid,
    input wire        out_ready,
    input wire [31:0] out_dest_id,
    input wire        out_last
);

    // A stalled forward stays offered
    `GMF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "forward dropped while stalled")
    // A stalled forward keeps its payload
    `GMF_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_dest_id) && $stable(out_last), "forward payload changed while stalled")
    // One message at a time: a transfer closes the input until the scan ends
    `GMF_ASSERT_NEXT(a_one_msg, clk, rst_n, in_valid && in_ready, !in_ready, "input open right after a transfer")
    // An idle block with an empty output register produces nothing new
    `GMF_ASSERT_NEXT(a_idle_quiet, clk, rst_n, in_ready && !out_valid, !out_valid, "forward appeared while idle")

endmodule

bind group_membership_fanout gmf_checker u_gmf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (msg_in.valid),
    .in_ready    (msg_in.ready),
    .out_valid   (fwd_out.valid),
    .out_ready   (fwd_out.ready),
    .out_dest_id (fwd_out.dest_id),
    .out_last    (fwd_out.last)
);

`default_nettype wire

[bench/group_membership_fanout_tb.sv]
// Testbench for group_membership_fanout: registers senders, fans messages out
// to group members and checks every forward against hand-written expectations or an in-bench table model.
// Depends on gmf_pkg, gmf_in_if, gmf_out_if and the block itself.
`timescale 1ns / 1ps

module group_membership_fanout_tb;
    import gmf_pkg::*;

    localparam int DEPTH        = TABLE_DEPTH_DEF;
    localparam int RAND_ITEMS   = 460;
    localparam int HOLD_CYCLES  = 500;
    localparam int DRAIN_CYCLES = 3 * DEPTH + 32;

    typedef enum int {
        OUT_REGISTERED,
        OUT_DROPPED,
        OUT_FORWARD
    } msg_outcome_t;

    typedef enum int {
        PICK_NEW,
        PICK_MEMBER,
        PICK_STRANGER,
        PICK_TURNED_AWAY
    } sender_pick_t;

    typedef struct packed {
        logic [ID_W-1:0] dest;
        logic            last;
    } fwd_t;

    // one directed message; hand-checked rows carry zero or one forward
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [GRP_W-1:0] fb;
        bit               hand_checked;
        bit               one_fwd;
        logic [ID_W-1:0]  fwd_dest;
    } dir_row_t;

    dir_row_t dir_rows [22] = '{
        '{32'h0000_0000, 8'h30, 1'b1, 1'b0, 32'h0},          // first member, group 0
        '{32'h0000_0000, 8'h41, 1'b1, 1'b0, 32'h0},          // alone in its group
        '{32'hFFFF_FFFF, 8'h30, 1'b1, 1'b0, 32'h0},
        '{32'h0000_0000, 8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
        '{32'hFFFF_FFFF, 8'h00, 1'b1, 1'b1, 32'h0000_0000},
        '{32'h0000_0001, 8'h00, 1'b1, 1'b0, 32'h0},          // group wraps below zero
        '{32'h0000_0002, 8'hFF, 1'b1, 1'b0, 32'h0},
        '{32'h0000_0003, 8'h2F, 1'b1, 1'b0, 32'h0},          // group 0xFF
        '{32'h0000_0002, 8'h00, 1'b1, 1'b0, 32'h0},
        '{32'h0000_0004, 8'h00, 1'b1, 1'b0, 32'h0},
        '{32'h0000_0001, 8'h30, 1'b1, 1'b1, 32'h0000_0004}, // byte ignored once known
        '{32'h0000_0004, 8'h7F, 1'b1, 1'b1, 32'h0000_0001},
        '{32'h0000_0005, 8'h30, 1'b1, 1'b0, 32'h0},
        '{32'hA5A5_5A5A, 8'h30, 1'b1, 1'b0, 32'h0},
        '{32'h8000_0000, 8'h80, 1'b1, 1'b0, 32'h0},
        '{32'h7FFF_FFFF, 8'h7F, 1'b1, 1'b0, 32'h0},
        '{32'h0000_0000, 8'h30, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0005, 8'h00, 1'b0, 1'b0, 32'h0},
        '{32'hA5A5_5A5A, 8'hAA, 1'b0, 1'b0, 32'h0},
        '{32'h1234_5678, 8'h31, 1'b1, 1'b0, 32'h0},
        '{32'h8000_0000, 8'h00, 1'b1, 1'b0, 32'h0},
        '{32'hFFFF_FFFF, 8'h55, 1'b0, 1'b0, 32'h0}
    };

    logic clk;
    logic rst_n;

    gmf_in_if  msg_ch();
    gmf_out_if fwd_ch();

    group_membership_fanout #(
        .TABLE_DEPTH(DEPTH)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg_in (msg_ch),
        .fwd_out(fwd_ch)
    );

    // membership table as the bench sees it
    logic [ID_W-1:0]  tbl_id [DEPTH];
    logic [GRP_W-1:0] tbl_grp [DEPTH];
    int               tbl_count;

    fwd_t             fwd_plan [$];
    fwd_t             fwd_pending [$];
    msg_outcome_t     outcome;
    logic [ID_W-1:0]  turned_away [$];

    bit quiet;
    int holds_asked;
    int mismatches;
    int msgs_sent;
    int regs_seen;
    int drops_seen;
    int fwds_checked;
    int widest_fanout;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // work out what one accepted message does to the table and which forwards it causes
    task automatic route_message(input logic [ID_W-1:0] id, input logic [GRP_W-1:0] fb);
        int pos;
        int i;
        logic [GRP_W-1:0] grp;
        fwd_t f;
        fwd_plan.delete();
        pos = -1;
        for (i = 0; i < tbl_count; i++)
            if (pos < 0 && tbl_id[i] == id)
                pos = i;
        if (pos < 0)
        begin
            if (tbl_count < DEPTH)
            begin
                tbl_id[tbl_count]  = id;
                tbl_grp[tbl_count] = fb - GROUP_BIAS;
                tbl_count++;
                outcome = OUT_REGISTERED;
            end
            else
            begin
                outcome = OUT_DROPPED;
            end
        end
        else
        begin
            outcome = OUT_FORWARD;
            grp = tbl_grp[pos];
            for (i = 0; i < tbl_count; i++)
            begin
                if (tbl_id[i] != id && tbl_grp[i] == grp && fwd_plan.size() < DEPTH - 1)
                begin
                    f.dest = tbl_id[i];
                    f.last = 1'b0;
                    fwd_plan.push_back(f);
                end
            end
            // mark the final forward
            if (fwd_plan.size() > 0)
            begin
                f = fwd_plan.pop_back();
                f.last = 1'b1;
                fwd_plan.push_back(f);
            end
        end
    endtask

    // offer one message, hold it until the transfer, then record what it should cause
    task automatic send_msg(input logic [ID_W-1:0] id, input logic [GRP_W-1:0] fb,
                            input bit hand_checked, input bit one_fwd,
                            input logic [ID_W-1:0] fwd_dest);
        int gap;
        fwd_t f;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            msg_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg_ch.valid      <= 1'b1;
        msg_ch.sender_id  <= id;
        msg_ch.first_byte <= fb;
        @(posedge clk);
        while (!msg_ch.ready)
            @(posedge clk);
        route_message(id, fb);
        msgs_sent++;
        if (outcome == OUT_REGISTERED)
            regs_seen++;
        if (outcome == OUT_DROPPED)
        begin
            drops_seen++;
            turned_away.push_back(id);
        end
        if (fwd_plan.size() > widest_fanout)
            widest_fanout = fwd_plan.size();
        if (hand_checked)
        begin
            if (one_fwd)
            begin
                f.dest = fwd_dest;
                f.last = 1'b1;
                fwd_pending.push_back(f);
            end
        end
        else
        begin
            foreach (fwd_plan[i])
                fwd_pending.push_back(fwd_plan[i]);
        end
    endtask

    // forward-channel receiver: random ready, with long hold-offs on request
    initial
    begin
        int gap;
        int holds_done;
        holds_done = 0;
        fwd_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (holds_done < holds_asked)
            begin
                holds_done++;
                fwd_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                gap = quiet ? 0 : pick_gap();
                if (gap == 0)
                begin
                    fwd_ch.ready <= 1'b1;
                    @(posedge clk);
                end
                else
                begin
                    fwd_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    // check each forward transfer against the oldest expectation
    always @(posedge clk)
    begin
        fwd_t f;
        if (rst_n && fwd_ch.valid && fwd_ch.ready)
        begin
            if (fwd_pending.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected forward dest_id=%h last=%b",
                         $time, fwd_ch.dest_id, fwd_ch.last);
            end
            else
            begin
                f = fwd_pending.pop_front();
                fwds_checked++;
                if (fwd_ch.dest_id !== f.dest)
                begin
                    mismatches++;
                    $display("%0t: dest_id expected %h actual %h", $time, f.dest, fwd_ch.dest_id);
                end
                if (fwd_ch.last !== f.last)
                begin
                    mismatches++;
                    $display("%0t: last expected %b actual %b (dest %h)",
                             $time, f.last, fwd_ch.last, f.dest);
                end
            end
        end
    end

    // stimulus: reset, directed table, then random traffic
    initial
    begin
        sender_pick_t pick;
        logic [ID_W-1:0]  id;
        logic [GRP_W-1:0] fb;
        int r;
        tbl_count     = 0;
        quiet         = 1'b0;
        holds_asked   = 0;
        mismatches    = 0;
        msgs_sent     = 0;
        regs_seen     = 0;
        drops_seen    = 0;
        fwds_checked  = 0;
        widest_fanout = 0;
        rst_n             <= 1'b0;
        msg_ch.valid      <= 1'b0;
        msg_ch.sender_id  <= '0;
        msg_ch.first_byte <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
            send_msg(dir_rows[k].id, dir_rows[k].fb, dir_rows[k].hand_checked,
                     dir_rows[k].one_fwd, dir_rows[k].fwd_dest);

        for (int k = 0; k < RAND_ITEMS; k++)
        begin
            // switch between idle-free stretches and normal traffic
            if (k % 40 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            // stall the receiver while messages keep coming
            if (k == RAND_ITEMS / 3 || k == (2 * RAND_ITEMS) / 3)
                holds_asked++;
            r = $urandom_range(0, 99);
            if (tbl_count < DEPTH)
                pick = (r < 60) ? PICK_NEW : PICK_MEMBER;
            else if (r < 80)
                pick = PICK_MEMBER;
            else if (r < 93 || turned_away.size() == 0)
                pick = PICK_STRANGER;
            else
                pick = PICK_TURNED_AWAY;
            case (pick)
                PICK_NEW, PICK_STRANGER:
                begin
                    id = $urandom();
                    fb = ($urandom_range(0, 9) < 7) ? 8'(8'h30 + $urandom_range(0, 3))
                                                     : 8'($urandom_range(0, 255));
                end
                PICK_MEMBER:
                begin
                    id = tbl_id[$urandom_range(0, tbl_count - 1)];
                    fb = 8'($urandom_range(0, 255));
                end
                default:
                begin
                    id = turned_away[$urandom_range(0, turned_away.size() - 1)];
                    fb = 8'($urandom_range(0, 255));
                end
            endcase
            send_msg(id, fb, 1'b0, 1'b0, '0);
        end
        msg_ch.valid <= 1'b0;

        // drain, then watch for stray forwards
        while (fwd_pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run: %0d messages, %0d registrations, %0d turned away at a full table.",
                 msgs_sent, regs_seen, drops_seen);
        $display("Run: %0d forwards checked, widest fan-out %0d, %0d receiver hold-offs.",
                 fwds_checked, widest_fanout, holds_asked);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // give up if the run hangs
    initial
    begin
        #(80_000_000);
        $display("%0t: timeout, %0d forwards still expected", $time, fwd_pending.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
